// File: hw/rtl/power_button_mode_controller_assert.svh
// Assertion macros for the power button controller RTL.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef POWER_BUTTON_MODE_CONTROLLER_ASSERT_SVH
`define POWER_BUTTON_MODE_CONTROLLER_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define PBMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbmc: same-cycle check failed");

// The consequence holds in the cycle after the condition.
`define PBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbmc: next-cycle check failed");

`endif

// File: hw/rtl/pbmc_pkg.sv
`timescale 1ns / 1ps

package pbmc_pkg;

	localparam int unsigned LEVEL_W    = 7;
	localparam int unsigned PWM_W      = 8;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned PRESS_W    = 11;
	localparam int unsigned BLINK_W    = 9;
	localparam int unsigned FW_W       = 12;
	localparam int unsigned LONG_W     = 10;
	localparam int unsigned HALF_W     = 8;
	localparam int unsigned PULSES_W   = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned DIV_STEPS  = FW_W;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [PRESS_W-1:0] PRESS_SAT = '1;

	// Mode codes as seen on the result channel.
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BREATHE = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAREWELL   = 2'd2;

	localparam logic [LONG_W-1:0]   LONG_PRESS_RST = 10'd100;
	localparam logic [HALF_W-1:0]   BLINK_HALF_RST = 8'd20;
	localparam logic [PULSES_W-1:0] FAREWELL_RST   = 3'd3;

	typedef struct packed {
		logic button;
		logic printing;
		logic halt_request;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] led_level;
		logic [PWM_W-1:0]   led_pwm;
		logic [MODE_W-1:0]  mode;
		logic               rails_enable;
		logic               controller_run;
		logic               home_request;
		logic               busy_farewell;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic [LONG_W-1:0]   long_press_ticks;
		logic [HALF_W-1:0]   blink_half_ticks;
		logic [PULSES_W-1:0] farewell_pulses;
	} cfg_regs_t;

	typedef struct packed {
		logic              start;
		logic [FW_W-1:0]   dividend;
		logic [HALF_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [HALF_W-1:0] rem;
		logic              odd;
	} div_res_t;

	typedef struct packed {
		logic            fw_active;
		logic [FW_W-1:0] fw_count;
	} core_status_t;

endpackage

// File: hw/rtl/pbmc_in_if.sv
`timescale 1ns / 1ps

interface pbmc_in_if;
	import pbmc_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pbmc_out_if.sv
`timescale 1ns / 1ps

interface pbmc_out_if;
	import pbmc_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pbmc_cfg_if.sv
`timescale 1ns / 1ps

interface pbmc_cfg_if;
	import pbmc_pkg::*;

	logic       valid;
	logic       ready;
	cfg_write_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/pbmc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Only the remainder and
// the parity of the quotient are kept.
module pbmc_div (
	input  logic             clk,
	input  logic             arst_n,
	input  pbmc_pkg::div_req_t req,
	output pbmc_pkg::div_res_t res
);
	import pbmc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FW_W-1:0]      num_q;
	logic [HALF_W-1:0]    den_q;
	logic [HALF_W-1:0]    rem_q;
	logic                 qbit_q;

	logic [HALF_W:0] trial;
	logic [HALF_W:0] diff;
	logic            take;

	assign trial = {rem_q, num_q[FW_W-1]};
	assign take  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			qbit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				num_q  <= req.dividend;
				den_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				num_q  <= {num_q[FW_W-2:0], 1'b0};
				rem_q  <= take ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
				qbit_q <= take;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.rem  = rem_q;
	assign res.odd  = qbit_q;
endmodule

// File: hw/rtl/pbmc_core.sv
`timescale 1ns / 1ps

// Controller state and the per-tick update. The next state and the result
// are computed in one pass from the registered tick and the current state.
module pbmc_core #(
	parameter int unsigned LEVEL_MAX = 100,
	parameter int unsigned PWM_MAX   = 255
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  pbmc_pkg::in_item_t      tick,
	input  pbmc_pkg::cfg_regs_t     cfg,
	input  pbmc_pkg::div_res_t      div_res,
	output pbmc_pkg::out_item_t     res,
	output pbmc_pkg::core_status_t  status
);
	import pbmc_pkg::*;

	localparam logic [LEVEL_W-1:0] LevelMax = LEVEL_W'(LEVEL_MAX);
	localparam int unsigned PwmCalcW = $clog2(PWM_MAX + 1) + LEVEL_W;
	localparam logic [PwmCalcW-1:0] PwmMax  = PwmCalcW'(PWM_MAX);
	localparam logic [PwmCalcW-1:0] PwmStep = PwmCalcW'(PWM_MAX / LEVEL_MAX);

	logic                prev_b_q, prev_p_q, prev_h_q, armed_q;
	logic [PRESS_W-1:0]  press_q;
	logic [MODE_W-1:0]   mode_q;
	logic [BLINK_W-1:0]  blink_q;
	logic [LEVEL_W-1:0]  breath_q;
	logic                falling_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                rails_q, run_q, home_q;
	logic [FW_W-1:0]     fw_count_q;
	logic [HALF_W-1:0]   fw_rem_q;
	logic                fw_odd_q;

	logic                n_prev_b, n_prev_p, n_prev_h, n_armed;
	logic [PRESS_W-1:0]  n_press;
	logic [MODE_W-1:0]   n_mode;
	logic [BLINK_W-1:0]  n_blink;
	logic [LEVEL_W-1:0]  n_breath;
	logic                n_falling;
	logic [LEVEL_W-1:0]  n_level;
	logic                n_rails, n_run, n_home;
	logic [FW_W-1:0]     n_fw_count;
	logic [HALF_W-1:0]   n_fw_rem;
	logic                n_fw_odd;

	logic                leaving;
	logic [HALF_W-1:0]   half_eff;
	logic [FW_W-2:0]     fw_prod;
	logic [FW_W-1:0]     fw_total;
	logic [PwmCalcW-1:0] pwm_full;

	assign half_eff = (cfg.blink_half_ticks == '0) ? HALF_W'(1) : cfg.blink_half_ticks;
	assign fw_prod  = {{(FW_W - 1 - PULSES_W){1'b0}}, cfg.farewell_pulses}
		* {{(FW_W - 1 - HALF_W){1'b0}}, cfg.blink_half_ticks};
	assign fw_total = {fw_prod, 1'b0};

	always_comb begin
		n_prev_b   = prev_b_q;
		n_prev_p   = prev_p_q;
		n_prev_h   = prev_h_q;
		n_armed    = armed_q;
		n_press    = press_q;
		n_mode     = mode_q;
		n_blink    = blink_q;
		n_breath   = breath_q;
		n_falling  = falling_q;
		n_level    = level_q;
		n_rails    = rails_q;
		n_run      = run_q;
		n_home     = home_q;
		n_fw_count = fw_count_q;
		n_fw_rem   = fw_rem_q;
		n_fw_odd   = fw_odd_q;
		leaving    = 1'b0;

		if (fw_count_q != '0) begin
			// Farewell in progress: inputs are ignored.
			if (fw_count_q <= FW_W'(1)) begin
				n_rails    = 1'b0;
				n_run      = 1'b0;
				n_level    = '0;
				n_mode     = MODE_OFF;
				n_fw_count = '0;
			end else begin
				n_level    = fw_odd_q ? '0 : LevelMax;
				n_fw_count = fw_count_q - FW_W'(1);
				if (fw_rem_q == '0) begin
					n_fw_rem = half_eff - HALF_W'(1);
					n_fw_odd = ~fw_odd_q;
				end else begin
					n_fw_rem = fw_rem_q - HALF_W'(1);
				end
			end
		end else begin
			n_prev_b = tick.button;
			n_prev_p = tick.printing;
			n_prev_h = tick.halt_request;

			if (tick.printing && !prev_p_q) begin
				n_mode = MODE_BREATHE;
			end else if (!tick.printing && prev_p_q) begin
				n_mode = MODE_ON;
			end

			leaving = tick.halt_request && !prev_h_q;

			if (!leaving && tick.button) begin
				if (!prev_b_q) begin
					n_press = '0;
					n_armed = 1'b1;
				end else if (armed_q) begin
					if (press_q != PRESS_SAT) begin
						n_press = press_q + PRESS_W'(1);
					end
					if (n_press > {1'b0, cfg.long_press_ticks}) begin
						n_armed = 1'b0;
						if (n_mode == MODE_OFF) begin
							n_rails = 1'b1;
							n_run   = 1'b1;
							n_level = LevelMax;
							n_mode  = MODE_ON;
						end else if (n_mode == MODE_ON) begin
							leaving = 1'b1;
						end else begin
							n_level = LevelMax;
							n_mode  = MODE_ON;
						end
					end
				end
			end

			if (!leaving && !tick.button && prev_b_q
				&& (press_q < {1'b0, cfg.long_press_ticks})) begin
				n_armed = 1'b0;
				if (n_mode == MODE_ON) begin
					n_home = 1'b1;
				end else if (n_mode == MODE_BLINK) begin
					n_mode = MODE_BREATHE;
				end
			end

			if (leaving) begin
				n_armed = 1'b0;
				if (fw_total == '0) begin
					n_rails    = 1'b0;
					n_run      = 1'b0;
					n_level    = '0;
					n_mode     = MODE_OFF;
					n_fw_count = '0;
				end else begin
					// First shown tick is the off half; the tracker then
					// points at the following tick.
					n_level    = '0;
					n_fw_count = fw_total;
					if (cfg.blink_half_ticks == HALF_W'(1)) begin
						n_fw_rem = '0;
						n_fw_odd = 1'b0;
					end else begin
						n_fw_rem = cfg.blink_half_ticks - HALF_W'(2);
						n_fw_odd = 1'b1;
					end
				end
			end else if (n_mode == MODE_BLINK) begin
				n_level = (blink_q < {1'b0, cfg.blink_half_ticks}) ? '0 : LevelMax;
				if (blink_q >= {cfg.blink_half_ticks, 1'b0}) begin
					n_blink = '0;
				end else begin
					n_blink = blink_q + BLINK_W'(1);
				end
			end else if (n_mode == MODE_BREATHE) begin
				n_level = breath_q;
				if (falling_q) begin
					if (breath_q != '0) begin
						n_breath = breath_q - LEVEL_W'(1);
					end
				end else if (breath_q < LevelMax) begin
					n_breath = breath_q + LEVEL_W'(1);
				end else begin
					n_breath = LevelMax;
				end
				if ((n_breath == LevelMax) || (n_breath == '0)) begin
					n_falling = ~falling_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_b_q   <= 1'b0;
			prev_p_q   <= 1'b0;
			prev_h_q   <= 1'b0;
			armed_q    <= 1'b0;
			press_q    <= '0;
			mode_q     <= MODE_OFF;
			blink_q    <= '0;
			breath_q   <= '0;
			falling_q  <= 1'b0;
			level_q    <= '0;
			rails_q    <= 1'b0;
			run_q      <= 1'b0;
			home_q     <= 1'b0;
			fw_count_q <= '0;
			fw_rem_q   <= '0;
			fw_odd_q   <= 1'b0;
		end else if (fire) begin
			prev_b_q   <= n_prev_b;
			prev_p_q   <= n_prev_p;
			prev_h_q   <= n_prev_h;
			armed_q    <= n_armed;
			press_q    <= n_press;
			mode_q     <= n_mode;
			blink_q    <= n_blink;
			breath_q   <= n_breath;
			falling_q  <= n_falling;
			level_q    <= n_level;
			rails_q    <= n_rails;
			run_q      <= n_run;
			home_q     <= n_home;
			fw_count_q <= n_fw_count;
			fw_rem_q   <= n_fw_rem;
			fw_odd_q   <= n_fw_odd;
		end else if (div_res.done) begin
			fw_rem_q <= div_res.rem;
			fw_odd_q <= div_res.odd;
		end
	end

	assign pwm_full = PwmMax - PwmStep * {{(PwmCalcW - LEVEL_W){1'b0}}, n_level};

	assign res.led_level      = n_level;
	assign res.led_pwm        = pwm_full[PWM_W-1:0];
	assign res.mode           = n_mode;
	assign res.rails_enable   = n_rails;
	assign res.controller_run = n_run;
	assign res.home_request   = n_home;
	assign res.busy_farewell  = n_fw_count != '0;

	assign status.fw_active = fw_count_q != '0;
	assign status.fw_count  = fw_count_q;
endmodule

// File: hw/rtl/power_button_mode_controller.sv
`timescale 1ns / 1ps

// Power button and mode controller. Each request on the item channel is one
// 10 ms tick carrying the button, printing and halt levels; each one yields
// exactly one request on the result channel with the LED level and PWM
// compare value, the mode, the rail and run enables, the latched home line
// and the farewell flag. The block takes one tick per clock cycle when not
// stalled: a tick lands in an input register, the whole state update runs
// in one pass of logic, and the result is held in an output register, so a
// stalled result does not stop the next tick from being registered. Another
// stall comes from the serial remainder unit: writing blink_half_ticks
// while a farewell blink is running recomputes the blink phase against the
// new half length, during which neither ticks nor further register writes
// are taken. Configuration writes are taken only when no tick sits in the
// input register, and a pending write holds off new ticks.
`include "power_button_mode_controller_assert.svh"

module power_button_mode_controller #(
	parameter int unsigned LEVEL_MAX = 100,
	parameter int unsigned PWM_MAX   = 255
) (
	input logic       clk,
	input logic       arst_n,
	pbmc_in_if.sink   item,
	pbmc_out_if.source result,
	pbmc_cfg_if.sink  cfg
);
	import pbmc_pkg::*;

	// Configuration registers.
	cfg_regs_t    cfg_q;

	// Input register stage.
	logic         valid_s1;
	in_item_t     item_s1;

	// Output register stage.
	logic         valid_s2;
	out_item_t    result_s2;

	logic         advance;
	logic         item_fire;
	logic         cfg_fire;
	out_item_t    core_res;
	core_status_t core_status;
	div_req_t     div_req;
	div_res_t     div_res;

	// A tick moves into the result register whenever that register is free
	// or being emptied in the same cycle.
	assign advance   = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !div_res.busy && !cfg.valid && (!valid_s1 || advance);
	assign item_fire = item.valid && item.ready;
	assign cfg.ready = !div_res.busy && !valid_s1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.blink_half_ticks <= BLINK_HALF_RST;
			cfg_q.farewell_pulses  <= FAREWELL_RST;
		end else if (cfg_fire) begin
			unique case (cfg.data.index)
				CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg.data.value[LONG_W-1:0];
				CFG_BLINK_HALF: cfg_q.blink_half_ticks <= cfg.data.value[HALF_W-1:0];
				CFG_FAREWELL:   cfg_q.farewell_pulses  <= cfg.data.value[PULSES_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_res;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	// A new half length during the farewell restarts the phase tracker:
	// the remaining ticks minus two are divided by the new half, where a
	// half of zero counts as one.
	assign div_req.start    = cfg_fire && (cfg.data.index == CFG_BLINK_HALF)
		&& core_status.fw_active;
	assign div_req.dividend = core_status.fw_count - FW_W'(2);
	assign div_req.divisor  = (cfg.data.value[HALF_W-1:0] == '0) ? HALF_W'(1)
		: cfg.data.value[HALF_W-1:0];

	pbmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	pbmc_core #(
		.LEVEL_MAX (LEVEL_MAX),
		.PWM_MAX   (PWM_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.tick    (item_s1),
		.cfg     (cfg_q),
		.div_res (div_res),
		.res     (core_res),
		.status  (core_status)
	);

	// A half-length write during the farewell must start the divider.
	`PBMC_ASSERT_NEXT(a_half_write_starts_div, clk, arst_n, div_req.start, div_res.busy)
	// No tick may be in flight while the phase tracker is being rebuilt.
	`PBMC_ASSERT_NOW(a_div_no_tick, clk, arst_n, div_res.busy, !valid_s1 && !item_fire)
	// Rails and controller run are always switched together.
	`PBMC_ASSERT_NOW(a_rails_run_pair, clk, arst_n, valid_s2,
		result_s2.rails_enable == result_s2.controller_run)
endmodule
